// ----- sv/chained_hash_integer_set_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash integer set
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_INTEGER_SET_CORE_ASSERT_SVH
`define CHAINED_HASH_INTEGER_SET_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CHIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CHIS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CHIS_ASSERT(lbl, prop, msg)
`define CHIS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- sv/chis_pkg.sv -----
// ----------------------------------------------------------------------------
// Chained hash integer set package
// Shared widths, codes, controller states and command/status structures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package chis_pkg;

  localparam int KEY_W   = 32;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 11;
  localparam int DIV_STEPS_W = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam logic [1:0] MODE_CONTAINS = 2'd0;
  localparam logic [1:0] MODE_ADD      = 2'd1;
  localparam logic [1:0] MODE_REMOVE   = 2'd2;
  localparam logic [1:0] MODE_NOP      = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_HEAD_RD,
    ST_HEAD_CAP,
    ST_NODE_RD,
    ST_NODE_CHK,
    ST_DECIDE,
    ST_FS_RD,
    ST_FS_CAP,
    ST_ADD_WR,
    ST_REM_WR,
    ST_FINISH
  } chis_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic head_cap;
    logic node_cap;
    logic fs_rd;
    logic fs_cap;
    logic alloc_fresh;
    logic pool_full;
    logic add_wr;
    logic rem_wr;
    logic out_load;
  } chis_cmd_t;

  typedef struct packed {
    logic       div_last;
    logic       walk_ok;
    logic       key_match;
    logic       found;
    logic       free_avail;
    logic       fresh_avail;
    logic       out_free;
    logic [1:0] mode;
  } chis_sts_t;

endpackage
`default_nettype wire

// ----- sv/chis_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output      logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/chis_datapath.sv -----
// ----------------------------------------------------------------------------
// Chained hash integer set datapath
// Modulo divider, chain walk registers, node memories, free stack, counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chis_datapath #(
  parameter int BUCKETS    = 256,
  parameter int POOL_NODES = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [chis_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic [1:0]                      mode_i,
  input  wire logic signed [chis_pkg::KEY_W-1:0] key_i,
  input  wire chis_pkg::chis_cmd_t             cmd_i,
  output      chis_pkg::chis_sts_t             sts_o,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic                            hit_o,
  output      logic                            status_o,
  output      logic [chis_pkg::COUNT_W-1:0]    entry_count_o
);
  import chis_pkg::*;

  localparam int PW = $clog2(POOL_NODES);
  localparam int BW = $clog2(BUCKETS);
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam logic [CFG_W-1:0] BC_MAX = (BUCKETS > 511) ? 9'd511 : CFG_W'(BUCKETS);

  logic [CFG_W-1:0]   bucket_count_q;
  logic [1:0]         mode_q;
  logic [KEY_W-1:0]   key_q, div_key_q;
  logic [CFG_W-1:0]   rem_q, bc_q, rem_d;
  logic [DIV_STEPS_W-1:0] div_cnt_q;
  logic [PW-1:0]      cur_q, prev_q, node_q, head_q;
  logic               cur_valid_q, has_prev_q, found_q;
  logic [PW:0]        link_q;
  logic [CW-1:0]      steps_q, free_top_q, fresh_q, held_q;
  logic [BUCKETS-1:0] hvalid_q;
  logic               hit_q, status_q;
  logic               out_valid_q, out_hit_q, out_status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic [CFG_W-1:0]   bc_sat;
  logic [CFG_W:0]     trial;
  logic [BW+CFG_W-1:0] bucket_ext;
  logic [BW-1:0]      bucket;
  logic [CW+COUNT_W-1:0] held_ext;
  logic [CW-1:0]      ftop_m1;

  logic [PW-1:0]      head_rdata, fs_rdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [PW:0]        link_rdata;
  logic               head_we, link_we, fs_we;
  logic [PW-1:0]      head_wdata, link_waddr;
  logic [PW:0]        link_wdata;

  // Saturated divisor: zero counts as one, large values clip to the bucket count.
  always_comb begin
    bc_sat = (bucket_count_q == '0) ? CFG_W'(1) : bucket_count_q;
    if (32'(bc_sat) > BUCKETS) begin
      bc_sat = BC_MAX;
    end
  end

  // One restoring division step per cycle.
  assign trial = {rem_q, div_key_q[KEY_W-1]};
  always_comb begin
    if (trial >= {1'b0, bc_q}) begin
      rem_d = CFG_W'(trial - {1'b0, bc_q});
    end else begin
      rem_d = trial[CFG_W-1:0];
    end
  end

  assign bucket_ext = {{BW{1'b0}}, rem_q};
  assign bucket     = bucket_ext[BW-1:0];
  assign held_ext   = {{COUNT_W{1'b0}}, held_q};
  assign ftop_m1    = free_top_q - CW'(1);

  // Memory write steering.
  assign head_we    = cmd_i.add_wr || (cmd_i.rem_wr && !has_prev_q);
  assign head_wdata = cmd_i.add_wr ? node_q : link_q[PW-1:0];
  assign link_we    = cmd_i.add_wr || (cmd_i.rem_wr && has_prev_q);
  assign link_waddr = cmd_i.add_wr ? node_q : prev_q;
  assign link_wdata = cmd_i.add_wr ? {hvalid_q[bucket], head_q} : link_q;
  assign fs_we      = cmd_i.rem_wr && (32'(free_top_q) < POOL_NODES);

  chis_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(bucket), .wdata_i(head_wdata),
    .raddr_i(bucket), .rdata_o(head_rdata)
  );

  chis_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_key_ram (
    .clk_i, .we_i(cmd_i.add_wr), .waddr_i(node_q), .wdata_i(key_q),
    .raddr_i(cur_q), .rdata_o(key_rdata)
  );

  chis_ram #(.WIDTH(PW + 1), .DEPTH(POOL_NODES)) u_link_ram (
    .clk_i, .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(cur_q), .rdata_o(link_rdata)
  );

  chis_ram #(.WIDTH(PW), .DEPTH(POOL_NODES)) u_free_ram (
    .clk_i, .we_i(fs_we), .waddr_i(free_top_q[PW-1:0]), .wdata_i(node_q),
    .raddr_i(ftop_m1[PW-1:0]), .rdata_o(fs_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= CFG_RESET;
      hvalid_q       <= '0;
      free_top_q     <= '0;
      fresh_q        <= '0;
      held_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bucket_count_q <= cfg_wdata_i;
      end
      if (cmd_i.fs_rd) begin
        free_top_q <= ftop_m1;
      end
      if (cmd_i.alloc_fresh) begin
        fresh_q <= fresh_q + CW'(1);
      end
      if (cmd_i.add_wr) begin
        hvalid_q[bucket] <= 1'b1;
        held_q           <= held_q + CW'(1);
      end
      if (cmd_i.rem_wr) begin
        if (!has_prev_q) begin
          hvalid_q[bucket] <= link_q[PW];
        end
        if (fs_we) begin
          free_top_q <= free_top_q + CW'(1);
        end
        if (held_q != '0) begin
          held_q <= held_q - CW'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= mode_i;
      key_q     <= key_i;
      div_key_q <= key_i;
      rem_q     <= '0;
      div_cnt_q <= '0;
      bc_q      <= bc_sat;
      found_q   <= 1'b0;
      hit_q     <= 1'b0;
      status_q  <= 1'b0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= rem_d;
      div_key_q <= {div_key_q[KEY_W-2:0], 1'b0};
      div_cnt_q <= div_cnt_q + DIV_STEPS_W'(1);
    end
    if (cmd_i.head_cap) begin
      cur_q       <= head_rdata;
      head_q      <= head_rdata;
      cur_valid_q <= hvalid_q[bucket];
      has_prev_q  <= 1'b0;
      steps_q     <= '0;
    end
    if (cmd_i.node_cap) begin
      if (key_rdata == key_q) begin
        found_q <= 1'b1;
        node_q  <= cur_q;
        link_q  <= link_rdata;
        if (mode_q == MODE_CONTAINS) begin
          hit_q <= 1'b1;
        end
      end else begin
        prev_q      <= cur_q;
        has_prev_q  <= 1'b1;
        cur_q       <= link_rdata[PW-1:0];
        cur_valid_q <= link_rdata[PW];
        steps_q     <= steps_q + CW'(1);
      end
    end
    if (cmd_i.fs_cap) begin
      node_q <= fs_rdata;
    end
    if (cmd_i.alloc_fresh) begin
      node_q <= fresh_q[PW-1:0];
    end
    if (cmd_i.pool_full) begin
      status_q <= 1'b1;
    end
    if (cmd_i.add_wr || cmd_i.rem_wr) begin
      hit_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_hit_q    <= hit_q;
      out_status_q <= status_q;
      out_count_q  <= held_ext[COUNT_W-1:0];
    end
  end

  always_comb begin
    sts_o.div_last    = (div_cnt_q == '1);
    sts_o.walk_ok     = cur_valid_q && (32'(steps_q) < POOL_NODES);
    sts_o.key_match   = (key_rdata == key_q);
    sts_o.found       = found_q;
    sts_o.free_avail  = (free_top_q != '0);
    sts_o.fresh_avail = (32'(fresh_q) < POOL_NODES);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
    sts_o.mode        = mode_q;
  end

  assign out_valid_o   = out_valid_q;
  assign hit_o         = out_hit_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_count_q;

endmodule
`default_nettype wire

// ----- sv/chis_ctrl.sv -----
// ----------------------------------------------------------------------------
// Chained hash integer set controller
// Sequences division, chain walk, allocation and chain update per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module chis_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire chis_pkg::chis_sts_t sts_i,
  output      chis_pkg::chis_cmd_t cmd_o
);
  import chis_pkg::*;

  chis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_DIV;
      ST_DIV:      if (sts_i.div_last) state_d = ST_HEAD_RD;
      ST_HEAD_RD:  state_d = ST_HEAD_CAP;
      ST_HEAD_CAP: state_d = ST_NODE_RD;
      ST_NODE_RD:  state_d = sts_i.walk_ok ? ST_NODE_CHK : ST_DECIDE;
      ST_NODE_CHK: state_d = sts_i.key_match ? ST_DECIDE : ST_NODE_RD;
      ST_DECIDE: begin
        state_d = ST_FINISH;
        if (sts_i.mode == MODE_ADD && !sts_i.found) begin
          if (sts_i.free_avail) begin
            state_d = ST_FS_RD;
          end else if (sts_i.fresh_avail) begin
            state_d = ST_ADD_WR;
          end
        end else if (sts_i.mode == MODE_REMOVE && sts_i.found) begin
          state_d = ST_REM_WR;
        end
      end
      ST_FS_RD:    state_d = ST_FS_CAP;
      ST_FS_CAP:   state_d = ST_ADD_WR;
      ST_ADD_WR:   state_d = ST_FINISH;
      ST_REM_WR:   state_d = ST_FINISH;
      ST_FINISH:   if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_HEAD_CAP: cmd_o.head_cap = 1'b1;
      ST_NODE_CHK: cmd_o.node_cap = 1'b1;
      ST_DECIDE: begin
        if (sts_i.mode == MODE_ADD && !sts_i.found && !sts_i.free_avail) begin
          cmd_o.alloc_fresh = sts_i.fresh_avail;
          cmd_o.pool_full   = !sts_i.fresh_avail;
        end
      end
      ST_FS_RD:    cmd_o.fs_rd = 1'b1;
      ST_FS_CAP:   cmd_o.fs_cap = 1'b1;
      ST_ADD_WR:   cmd_o.add_wr = 1'b1;
      ST_REM_WR:   cmd_o.rem_wr = 1'b1;
      ST_FINISH:   cmd_o.out_load = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/chained_hash_integer_set_core.sv -----
// Sequence: each request runs the bit-serial modulo, the head read and capture,
// then a read and a key check per chain node visited, then the decision, the
// free stack read and capture for an add that reuses a node, the add or remove
// update, and the result load. Throughput: one request at a time.
// Reset: asynchronous, active low; counters and bucket valid bits clear at once.
// The bucket count returns to 256. There is no memory clearing pass.
// ----------------------------------------------------------------------------
// Chained hash integer set core
// Set of 32-bit integers in hash buckets with linked chains from a node pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_integer_set_core_assert.svh"
module chained_hash_integer_set_core #(
  parameter int BUCKETS    = 256,
  parameter int POOL_NODES = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [chis_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [1:0]                        mode_i,
  input  wire logic signed [chis_pkg::KEY_W-1:0] key_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              hit_o,
  output      logic                              status_o,
  output      logic [chis_pkg::COUNT_W-1:0]      entry_count_o
);
  import chis_pkg::*;

  // The controller walks one request through: bucket modulo, head read, a
  // read and a key check per chain node, then allocation or unlinking as the
  // mode asks. The result sits in an output register, so a new request is
  // taken while the previous result still waits downstream.
  chis_cmd_t cmd;
  chis_sts_t sts;

  chis_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  // The datapath holds the bucket count register, the node memories, the
  // free stack and the running entry count.
  chis_datapath #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .mode_i, .key_i,
    .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_stall_i,
    .hit_o, .status_o, .entry_count_o
  );

  // Once a request is taken the block is busy in the following cycle.
  `CHIS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "core not busy")
  // A node is only unlinked after the walk found it.
  `CHIS_ASSERT(a_remove_found, !cmd.rem_wr || sts.found, "remove without a matching node")
  // A node is only linked in when the key was absent.
  `CHIS_ASSERT(a_add_absent, !cmd.add_wr || !sts.found, "add for a key already present")
  // A loaded result is presented on the next cycle.
  `CHIS_ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid_o, "loaded result not presented")

endmodule
`default_nettype wire

// ----- verif/tb_chained_hash_integer_set_core.sv -----
// ----------------------------------------------------------------------------
// Chained hash integer set core testbench
// Drives contains, add and remove requests, predicts each result from a local
// model of the buckets, node pool and free stack, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_chained_hash_integer_set_core;
  import chis_pkg::*;

  localparam int NBUCK = 256;
  localparam int NPOOL = 1024;
  localparam int LAT   = 37 + 2 * NPOOL + 20;

  typedef struct packed {
    logic                 hit;
    logic                 status;
    logic [COUNT_W-1:0]   count;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = MODE_CONTAINS;
  logic signed [KEY_W-1:0] key_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic status_o;
  logic [COUNT_W-1:0] entry_count_o;

  chained_hash_integer_set_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .mode_i, .key_i, .out_valid_o, .out_stall_i, .hit_o, .status_o,
    .entry_count_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #80ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Shadow copy of the set. The set is tracked as a list of nodes so that
  // keys stranded by a change of bucket count behave exactly as in hardware.
  logic [CFG_W-1:0] div_reg;
  logic [31:0] node_key_m [NPOOL];
  int          node_bucket_m [NPOOL];
  bit          node_used_m [NPOOL];
  int          free_stack_m [$];
  int          fresh_m;
  int          held_m;

  set_result_t result_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;

  function automatic set_result_t predict_request(logic [1:0] mode, logic [31:0] key);
    set_result_t r;
    int bc;
    int b;
    int found;
    bc = (div_reg == 0) ? 1 : (div_reg > NBUCK ? NBUCK : int'(div_reg));
    b = int'(key % bc);
    found = -1;
    for (int n = 0; n < NPOOL; n++)
      if (node_used_m[n] && node_bucket_m[n] == b && node_key_m[n] == key) found = n;
    r = '0;
    case (mode)
      MODE_CONTAINS: r.hit = (found >= 0);
      MODE_ADD: begin
        if (found < 0) begin
          if (free_stack_m.size() > 0) found = free_stack_m.pop_back();
          else if (fresh_m < NPOOL) found = fresh_m++;
          if (found >= 0) begin
            node_used_m[found] = 1'b1;
            node_key_m[found] = key;
            node_bucket_m[found] = b;
            held_m++;
            r.hit = 1'b1;
          end else begin
            r.status = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (found >= 0) begin
          node_used_m[found] = 1'b0;
          free_stack_m.push_back(found);
          held_m--;
          r.hit = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = held_m[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Result checker: the oldest expectation is compared with each accepted result.
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = result_q.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (entry_count_o !== want.count)
          report_mismatch("entry_count", entry_count_o, want.count);
      end
    end
  end

  // Receiver stall, random or held off for a long stretch on request.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Valid stays up after acceptance until the next request or an idle cycle
  // replaces it, so the line is written once per clock edge.
  task automatic send_request(input logic [1:0] mode, input logic [31:0] key);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    key_i <= key;
    result_q.push_back(predict_request(mode, key));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    idle_input();
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    div_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key(int span);
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(span);
      default: return $urandom_range(span);
    endcase
  endfunction

  // Extremes of the key, every mode, duplicates, absent keys and the no-op mode.
  task automatic test_directed();
    send_request(MODE_CONTAINS, 32'h0);
    send_request(MODE_ADD, 32'h0);
    send_request(MODE_ADD, 32'h0);
    send_request(MODE_ADD, 32'hFFFF_FFFF);
    send_request(MODE_ADD, 32'h8000_0000);
    send_request(MODE_ADD, 32'h7FFF_FFFF);
    send_request(MODE_ADD, 32'h100);
    send_request(MODE_CONTAINS, 32'h8000_0000);
    send_request(MODE_CONTAINS, 32'h200);
    send_request(MODE_NOP, 32'h0);
    send_request(MODE_NOP, 32'hFFFF_FFFF);
    send_request(MODE_REMOVE, 32'h0);
    send_request(MODE_REMOVE, 32'h0);
    send_request(MODE_REMOVE, 32'h100);
    send_request(MODE_CONTAINS, 32'h7FFF_FFFF);
    send_request(MODE_ADD, 32'h0);
  endtask

  // Divisor extremes, including zero, above range, and keys stranded by change.
  task automatic test_bucket_counts();
    write_bucket_count(9'd1);
    for (int i = 0; i < 6; i++) send_request(MODE_ADD, i * 7);
    send_request(MODE_REMOVE, 32'd14);
    send_request(MODE_CONTAINS, 32'd7);
    write_bucket_count(9'd0);
    send_request(MODE_CONTAINS, 32'd21);
    write_bucket_count(9'h1FF);
    send_request(MODE_CONTAINS, 32'd35);
    send_request(MODE_ADD, 32'd35);
    write_bucket_count(9'd256);
    send_request(MODE_CONTAINS, 32'd35);
  endtask

  task automatic test_random(input int n, input int span);
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      m = ($urandom_range(19) == 0) ? MODE_NOP : 2'($urandom_range(2));
      send_request(m, pick_key(span));
    end
  endtask

  // Receiver holds off while requests keep coming, then the sender waits.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        test_random(20, 40);
        idle_input();
      end
    join
    drain_results();
  endtask

  // A long run of adds into few buckets builds deep chains, then a remove
  // frees a node that the following add takes back from the free stack.
  task automatic test_deep_chains();
    write_bucket_count(9'd4);
    recv_idle_pct = 0;
    send_idle_pct = 0;
    for (int i = 0; i < 207; i++) send_request(MODE_ADD, 32'h4000_0000 + i * 3);
    send_request(MODE_REMOVE, 32'h4000_0003);
    send_request(MODE_ADD, 32'h5555_5555);
    send_request(MODE_ADD, 32'h5555_5556);
  endtask

  initial begin
    div_reg = CFG_RESET;
    fresh_m = 0;
    held_m = 0;
    for (int n = 0; n < NPOOL; n++) node_used_m[n] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 13; recv_idle_pct = 63;
    test_directed();
    test_bucket_counts();
    write_bucket_count(9'd17);
    test_random(150, 60);
    test_backpressure();
    send_idle_pct = 63; recv_idle_pct = 13;
    write_bucket_count(9'd3);
    test_random(120, 40);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_bucket_count(9'd200);
    test_random(120, 500);
    test_deep_chains();

    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/chis_pkg.sv
sv/chis_ram.sv
sv/chis_datapath.sv
sv/chis_ctrl.sv
sv/chained_hash_integer_set_core.sv
verif/tb_chained_hash_integer_set_core.sv
